// ===== rtl/assert_macros.svh =====
// Assertion helpers for the particle pool blocks.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define PPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    `PPU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/ppu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the particle pool update block.
// No dependencies; used by ppu_ctrl, ppu_dpath and particle_pool_update.
package ppu_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 32;
    localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    // Field widths
    localparam int DT_W    = 16;
    localparam int POS_W   = 24;
    localparam int RAND_W  = 7;
    localparam int GRAY_W  = 9;
    localparam int ALPHA_W = 9;
    localparam int LIFE_W  = 17;
    localparam int FADE_W  = 12;
    localparam int VSC_W   = 16;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_LIFE  = 2'd2;
    localparam logic [FADE_W-1:0]    FADE_RATE_RST   = 12'd640;
    localparam logic [VSC_W-1:0]     VEL_SCALE_RST   = 16'd6554;
    localparam logic [LIFE_W-1:0]    SPAWN_LIFE_RST  = 17'd65536;

    // Item kinds
    localparam logic CMD_SPAWN = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPAWN_MUL,
        ST_SPAWN_WR,
        ST_TICK_FADE,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_TICK_WR
    } t_state;

    // One input item, without its kind
    typedef struct packed {
        logic        [RAND_W-1:0] rand_color;
        logic signed [RAND_W-1:0] rand_pos;
        logic signed [POS_W-1:0]  offset_y;
        logic signed [POS_W-1:0]  offset_x;
        logic signed [POS_W-1:0]  obj_vel_y;
        logic signed [POS_W-1:0]  obj_vel_x;
        logic signed [POS_W-1:0]  obj_pos_y;
        logic signed [POS_W-1:0]  obj_pos_x;
        logic        [DT_W-1:0]   tick_dt;
    } t_in_item;

    // Controller to datapath
    typedef struct packed {
        logic              latch_in;
        logic              spawn_mul;
        logic              spawn_wr;
        logic              fade_calc;
        logic              rd_en;
        logic              tick_mul;
        logic              tick_wr;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] rd_slot;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_alive;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/particle_pool_update.sv =====
`timescale 1ns / 1ps
// Top level of the particle pool update block: port packing, controller
// and datapath. Depends on ppu_pkg, ppu_ctrl and ppu_dpath.
//
//  channel   direction  beat                          handshake
//  s_axis    in         one spawn or tick command     tvalid / tready
//  m_axis    out        one slot state, tlast at end  tvalid / tready
//  cfg       in         register index and value      i_cfg_valid / o_cfg_ready
//
// A spawn runs the free-slot search, which checks one slot per cycle from
// the last used slot. A tick reads, multiplies and writes back each slot
// in turn through the single read port of the slot store, the next read
// overlapped with the write back.
// A stall on m_axis holds the tick at the current slot. Synchronous
// active-low reset empties the pool; config writes are taken at any time.

module particle_pool_update (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] tick_dt, [39:16] obj_pos_x, [63:40] obj_pos_y,
    // [87:64] obj_vel_x, [111:88] obj_vel_y, [135:112] offset_x,
    // [159:136] offset_y, [166:160] rand_pos, [173:167] rand_color
    input  logic [175:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] out_pos_x, [47:24] out_pos_y, [56:48] out_gray, [65:57] out_alpha
    output logic [71:0]  m_axis_tdata,
    // [0] out_alive
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [ppu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppu_pkg::LIFE_W-1:0]    i_cfg_data
);

    ppu_pkg::t_dp_cmd  dp_cmd;
    ppu_pkg::t_dp_stat dp_stat;
    ppu_pkg::t_in_item in_item;
    logic signed [ppu_pkg::POS_W-1:0] out_pos_x, out_pos_y;
    logic [ppu_pkg::GRAY_W-1:0]       out_gray;
    logic [ppu_pkg::ALPHA_W-1:0]      out_alpha;
    logic                             out_alive;

    // Unpack the input beat
    assign in_item = s_axis_tdata[173:0];

    assign o_cfg_ready = 1'b1;

    ppu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ppu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_item      (in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_alive (out_alive),
        .o_out_pos_x (out_pos_x),
        .o_out_pos_y (out_pos_y),
        .o_out_gray  (out_gray),
        .o_out_alpha (out_alpha),
        .o_out_last  (m_axis_tlast)
    );

    // Pack the output beat
    assign m_axis_tdata = {6'd0, out_alpha, out_gray, out_pos_y, out_pos_x};
    assign m_axis_tuser = out_alive;

endmodule

// ===== rtl/ppu_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the particle pool: slot search, spawn and tick sequencing.
// Depends on ppu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_ready,
    input  ppu_pkg::t_dp_stat  i_stat,
    output ppu_pkg::t_dp_cmd   o_cmd
);

    localparam logic [ppu_pkg::SLOT_W-1:0] LAST_SLOT =
        ppu_pkg::SLOT_W'(ppu_pkg::POOL_SIZE - 1);

    ppu_pkg::t_state r_state, n_state;
    logic [ppu_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [ppu_pkg::SLOT_W-1:0] r_steps, n_steps;
    logic [ppu_pkg::SLOT_W-1:0] r_last_used, n_last_used;
    logic accept;

    assign o_in_ready = (r_state == ppu_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppu_pkg::ST_IDLE;
            r_slot      <= '0;
            r_steps     <= '0;
            r_last_used <= '0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_steps     <= n_steps;
            r_last_used <= n_last_used;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_steps       = r_steps;
        n_last_used   = r_last_used;
        o_cmd         = '0;
        o_cmd.slot    = r_slot;
        o_cmd.rd_slot = r_slot;
        case (r_state)
            ppu_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch_in = 1'b1;
                    if (i_in_cmd == ppu_pkg::CMD_SPAWN) begin
                        n_slot  = r_last_used;
                        n_steps = '0;
                        n_state = ppu_pkg::ST_SCAN;
                    end else begin
                        n_state = ppu_pkg::ST_TICK_FADE;
                    end
                end
            end
            // Look at one slot a cycle, wrapping from the last used one
            ppu_pkg::ST_SCAN: begin
                if (!i_stat.slot_alive) begin
                    n_last_used = r_slot;
                    n_state     = ppu_pkg::ST_SPAWN_MUL;
                end else if (r_steps == LAST_SLOT) begin
                    n_slot      = '0;
                    n_last_used = '0;
                    n_state     = ppu_pkg::ST_SPAWN_MUL;
                end else begin
                    n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                    n_steps = r_steps + 1'b1;
                end
            end
            ppu_pkg::ST_SPAWN_MUL: begin
                o_cmd.spawn_mul = 1'b1;
                n_state         = ppu_pkg::ST_SPAWN_WR;
            end
            ppu_pkg::ST_SPAWN_WR: begin
                o_cmd.spawn_wr = 1'b1;
                n_state        = ppu_pkg::ST_IDLE;
            end
            ppu_pkg::ST_TICK_FADE: begin
                o_cmd.fade_calc = 1'b1;
                n_slot          = '0;
                n_state         = ppu_pkg::ST_TICK_RD;
            end
            ppu_pkg::ST_TICK_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ppu_pkg::ST_TICK_MUL;
            end
            ppu_pkg::ST_TICK_MUL: begin
                o_cmd.tick_mul = 1'b1;
                n_state        = ppu_pkg::ST_TICK_WR;
            end
            // Write back one slot and fetch the next while the beat goes out
            ppu_pkg::ST_TICK_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.tick_wr = 1'b1;
                    if (r_slot == LAST_SLOT) begin
                        n_state = ppu_pkg::ST_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_slot = r_slot + 1'b1;
                        n_slot        = r_slot + 1'b1;
                        n_state       = ppu_pkg::ST_TICK_MUL;
                    end
                end
            end
            default: begin
                n_state = ppu_pkg::ST_IDLE;
            end
        endcase
    end

    `PPU_ASSERT(a_wr_needs_room, o_cmd.tick_wr |-> i_stat.out_free, "tick write without room")
    `PPU_ASSERT_NEXT(a_tick_starts, accept && (i_in_cmd == ppu_pkg::CMD_TICK), r_state == ppu_pkg::ST_TICK_FADE, "tick did not start")
    `PPU_ASSERT_NEXT(a_spawn_ends, r_state == ppu_pkg::ST_SPAWN_WR, r_state == ppu_pkg::ST_IDLE, "spawn did not end")

endmodule

// ===== rtl/ppu_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the particle pool: config registers, slot stores, spawn and
// tick arithmetic, output register. Depends on ppu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppu_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppu_pkg::t_dp_cmd                    i_cmd,
    output ppu_pkg::t_dp_stat                   o_stat,
    input  ppu_pkg::t_in_item                   i_item,
    input  logic                                i_cfg_valid,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppu_pkg::LIFE_W-1:0]          i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_out_alive,
    output logic signed [ppu_pkg::POS_W-1:0]    o_out_pos_x,
    output logic signed [ppu_pkg::POS_W-1:0]    o_out_pos_y,
    output logic [ppu_pkg::GRAY_W-1:0]          o_out_gray,
    output logic [ppu_pkg::ALPHA_W-1:0]         o_out_alpha,
    output logic                                o_out_last
);

    localparam int N = ppu_pkg::POOL_SIZE;
    localparam logic [ppu_pkg::SLOT_W-1:0] LAST_SLOT = ppu_pkg::SLOT_W'(N - 1);
    // x / 10 for x below 43699 and x / 100 for x below 2^15
    localparam logic [15:0] RECIP_10  = 16'd52429;
    localparam logic [15:0] RECIP_100 = 16'd41944;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -26'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    // Config registers
    logic [ppu_pkg::FADE_W-1:0] r_fade_rate;
    logic [ppu_pkg::VSC_W-1:0]  r_vel_scale;
    logic [ppu_pkg::LIFE_W-1:0] r_spawn_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_rate  <= ppu_pkg::FADE_RATE_RST;
            r_vel_scale  <= ppu_pkg::VEL_SCALE_RST;
            r_spawn_life <= ppu_pkg::SPAWN_LIFE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppu_pkg::CFG_FADE_RATE:  r_fade_rate  <= i_cfg_data[ppu_pkg::FADE_W-1:0];
                ppu_pkg::CFG_VEL_SCALE:  r_vel_scale  <= i_cfg_data[ppu_pkg::VSC_W-1:0];
                ppu_pkg::CFG_SPAWN_LIFE: r_spawn_life <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Latched item
    ppu_pkg::t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_item <= i_item;
        end
    end

    // Slot stores, flags and registered read port
    logic [ppu_pkg::LIFE_W-1:0]        r_life_mem  [N];
    logic signed [ppu_pkg::POS_W-1:0]  r_px_mem    [N];
    logic signed [ppu_pkg::POS_W-1:0]  r_py_mem    [N];
    logic signed [ppu_pkg::POS_W-1:0]  r_vx_mem    [N];
    logic signed [ppu_pkg::POS_W-1:0]  r_vy_mem    [N];
    logic [ppu_pkg::GRAY_W-1:0]        r_gray_mem  [N];
    logic [ppu_pkg::ALPHA_W-1:0]       r_alpha_mem [N];
    logic [N-1:0] r_alive;
    logic [N-1:0] r_written;

    logic [ppu_pkg::LIFE_W-1:0]        r_rd_life;
    logic signed [ppu_pkg::POS_W-1:0]  r_rd_px, r_rd_py, r_rd_vx, r_rd_vy;
    logic [ppu_pkg::GRAY_W-1:0]        r_rd_gray;
    logic [ppu_pkg::ALPHA_W-1:0]       r_rd_alpha;
    logic                              r_rd_alive, r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_life    <= r_life_mem[i_cmd.rd_slot];
            r_rd_px      <= r_px_mem[i_cmd.rd_slot];
            r_rd_py      <= r_py_mem[i_cmd.rd_slot];
            r_rd_vx      <= r_vx_mem[i_cmd.rd_slot];
            r_rd_vy      <= r_vy_mem[i_cmd.rd_slot];
            r_rd_gray    <= r_gray_mem[i_cmd.rd_slot];
            r_rd_alpha   <= r_alpha_mem[i_cmd.rd_slot];
            r_rd_alive   <= r_alive[i_cmd.rd_slot];
            r_rd_written <= r_written[i_cmd.rd_slot];
        end
    end

    // Unwritten entries read as zero, dead ones have zero life
    logic [ppu_pkg::LIFE_W-1:0]        rd_life;
    logic signed [ppu_pkg::POS_W-1:0]  rd_px, rd_py, rd_vx, rd_vy;
    logic [ppu_pkg::GRAY_W-1:0]        rd_gray;
    logic [ppu_pkg::ALPHA_W-1:0]       rd_alpha;

    assign rd_life  = r_rd_alive   ? r_rd_life  : '0;
    assign rd_px    = r_rd_written ? r_rd_px    : '0;
    assign rd_py    = r_rd_written ? r_rd_py    : '0;
    assign rd_vx    = r_rd_written ? r_rd_vx    : '0;
    assign rd_vy    = r_rd_written ? r_rd_vy    : '0;
    assign rd_gray  = r_rd_written ? r_rd_gray  : '0;
    assign rd_alpha = r_rd_written ? r_rd_alpha : '0;

    // Shared velocity multipliers: object velocity by scale, or stored
    // velocity by delta time
    logic signed [ppu_pkg::POS_W-1:0] mul_ax, mul_ay;
    logic signed [16:0]               mul_b;
    logic signed [40:0]               r_vprod_x, r_vprod_y;
    logic [6:0]                       rp_mag;
    logic [14:0]                      jit_num, gray_num;
    logic [30:0]                      r_jit_prod, r_gray_prod;
    logic                             r_jit_neg;
    logic [12:0]                      r_fade;

    assign mul_ax   = i_cmd.tick_mul ? rd_vx : r_item.obj_vel_x;
    assign mul_ay   = i_cmd.tick_mul ? rd_vy : r_item.obj_vel_y;
    assign mul_b    = i_cmd.tick_mul ? $signed({1'b0, r_item.tick_dt})
                                     : $signed({1'b0, r_vel_scale});
    assign rp_mag   = r_item.rand_pos[ppu_pkg::RAND_W-1] ? 7'(-r_item.rand_pos)
                                                         : r_item.rand_pos;
    assign jit_num  = {rp_mag, 8'd0} + 15'd5;
    assign gray_num = {r_item.rand_color, 8'd0} + 15'd50;

    always_ff @(posedge i_clk) begin
        if (i_cmd.spawn_mul || i_cmd.tick_mul) begin
            r_vprod_x <= mul_ax * mul_b;
            r_vprod_y <= mul_ay * mul_b;
        end
        if (i_cmd.spawn_mul) begin
            r_jit_prod  <= 31'(jit_num) * 31'(RECIP_10);
            r_gray_prod <= 31'(gray_num) * 31'(RECIP_100);
            r_jit_neg   <= r_item.rand_pos[ppu_pkg::RAND_W-1];
        end
        if (i_cmd.fade_calc) begin
            r_fade <= 13'((29'(r_item.tick_dt) * 29'(r_fade_rate) + 29'd32768) >> 16);
        end
    end

    // Round the velocity products to Q16.8
    logic signed [40:0] vsum_x, vsum_y;
    logic signed [24:0] vrnd_x, vrnd_y;

    assign vsum_x = r_vprod_x + 41'sd32768;
    assign vsum_y = r_vprod_y + 41'sd32768;
    assign vrnd_x = vsum_x[40:16];
    assign vrnd_y = vsum_y[40:16];

    // Spawn values
    logic signed [12:0]               jit;
    logic [9:0]                       gray_sum;
    logic signed [ppu_pkg::POS_W-1:0] sp_px, sp_py, sp_vx, sp_vy;
    logic [ppu_pkg::GRAY_W-1:0]       sp_gray;

    assign jit      = r_jit_neg ? -$signed({2'b00, r_jit_prod[29:19]})
                                : $signed({2'b00, r_jit_prod[29:19]});
    assign gray_sum = 10'd128 + 10'(r_gray_prod[30:22]);
    assign sp_gray  = (gray_sum > 10'd511) ? 9'd511 : gray_sum[8:0];
    assign sp_px    = sat24(26'(r_item.obj_pos_x) + 26'(jit) + 26'(r_item.offset_x));
    assign sp_py    = sat24(26'(r_item.obj_pos_y) + 26'(jit) + 26'(r_item.offset_y));
    assign sp_vx    = sat24(26'(vrnd_x));
    assign sp_vy    = sat24(26'(vrnd_y));

    // Tick values
    logic                             tk_live;
    logic [ppu_pkg::LIFE_W-1:0]       tk_life;
    logic signed [ppu_pkg::POS_W-1:0] tk_px, tk_py;
    logic [ppu_pkg::ALPHA_W-1:0]      tk_alpha;

    assign tk_live  = rd_life > ppu_pkg::LIFE_W'(r_item.tick_dt);
    assign tk_life  = tk_live ? rd_life - ppu_pkg::LIFE_W'(r_item.tick_dt) : '0;
    assign tk_px    = tk_live ? sat24(26'(rd_px) - 26'(vrnd_x)) : rd_px;
    assign tk_py    = tk_live ? sat24(26'(rd_py) - 26'(vrnd_y)) : rd_py;
    assign tk_alpha = !tk_live ? rd_alpha
                    : ({4'd0, rd_alpha} > r_fade) ? rd_alpha - r_fade[8:0] : '0;

    // Write port
    logic                             wr_en, wr_alive;
    logic [ppu_pkg::LIFE_W-1:0]       wr_life;
    logic signed [ppu_pkg::POS_W-1:0] wr_px, wr_py, wr_vx, wr_vy;
    logic [ppu_pkg::GRAY_W-1:0]       wr_gray;
    logic [ppu_pkg::ALPHA_W-1:0]      wr_alpha;

    assign wr_en    = i_cmd.spawn_wr || i_cmd.tick_wr;
    assign wr_life  = i_cmd.spawn_wr ? r_spawn_life : tk_life;
    assign wr_alive = i_cmd.spawn_wr ? (r_spawn_life != '0) : tk_live;
    assign wr_px    = i_cmd.spawn_wr ? sp_px : tk_px;
    assign wr_py    = i_cmd.spawn_wr ? sp_py : tk_py;
    assign wr_vx    = i_cmd.spawn_wr ? sp_vx : rd_vx;
    assign wr_vy    = i_cmd.spawn_wr ? sp_vy : rd_vy;
    assign wr_gray  = i_cmd.spawn_wr ? sp_gray : rd_gray;
    assign wr_alpha = i_cmd.spawn_wr ? 9'd256 : tk_alpha;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_life_mem[i_cmd.slot]  <= wr_life;
            r_px_mem[i_cmd.slot]    <= wr_px;
            r_py_mem[i_cmd.slot]    <= wr_py;
            r_vx_mem[i_cmd.slot]    <= wr_vx;
            r_vy_mem[i_cmd.slot]    <= wr_vy;
            r_gray_mem[i_cmd.slot]  <= wr_gray;
            r_alpha_mem[i_cmd.slot] <= wr_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive   <= '0;
            r_written <= '0;
        end else if (wr_en) begin
            r_alive[i_cmd.slot]   <= wr_alive;
            r_written[i_cmd.slot] <= 1'b1;
        end
    end

    // Output register: hold the beat until taken
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.tick_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_wr) begin
            o_out_alive <= tk_live;
            o_out_pos_x <= tk_px;
            o_out_pos_y <= tk_py;
            o_out_gray  <= rd_gray;
            o_out_alpha <= tk_alpha;
            o_out_last  <= (i_cmd.slot == LAST_SLOT);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.slot_alive = r_alive[i_cmd.slot];

    `PPU_ASSERT_NEXT(a_spawn_alive, i_cmd.spawn_wr, r_alive[$past(i_cmd.slot)] == ($past(r_spawn_life) != '0), "spawned slot liveness wrong")
    `PPU_ASSERT_NEXT(a_tick_beat, i_cmd.tick_wr, r_out_valid, "tick write gave no beat")
    `PPU_ASSERT_NEXT(a_beat_held, r_out_valid && !i_out_ready, r_out_valid && $stable(o_out_pos_x), "stalled beat not held")

endmodule

// ===== test/particle_pool_update_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for particle_pool_update: spawn and tick beats go in on s_axis,
// every slot beat of a tick is checked against a bit-true model of the pool.
// Depends on ppu_pkg and the particle_pool_update RTL.
module particle_pool_update_test;
    import ppu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // cycles to let a spawn that emits nothing finish before a register write
    localparam int SETTLE_CYCLES  = 2 * POOL_SIZE + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic                    alive;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [GRAY_W-1:0]       gray;
        logic [ALPHA_W-1:0]      alpha;
        logic                    last;
    } t_slot_beat;

    // Pool model and store of the slot beats still to come
    class pool_scoreboard;
        logic [FADE_W-1:0]       fade_rate;
        logic [VSC_W-1:0]        vel_scale;
        logic [LIFE_W-1:0]       spawn_life;
        logic [LIFE_W-1:0]       life   [POOL_SIZE];
        logic signed [POS_W-1:0] pos_x  [POOL_SIZE];
        logic signed [POS_W-1:0] pos_y  [POOL_SIZE];
        logic signed [POS_W-1:0] vel_x  [POOL_SIZE];
        logic signed [POS_W-1:0] vel_y  [POOL_SIZE];
        logic [GRAY_W-1:0]       gray   [POOL_SIZE];
        logic [ALPHA_W-1:0]      alpha  [POOL_SIZE];
        int                      last_slot;
        t_slot_beat              expected_slots[$];
        int                      errors;
        int                      spawns;
        int                      ticks;
        int                      beats_checked;

        function new();
            fade_rate  = FADE_RATE_RST;
            vel_scale  = VEL_SCALE_RST;
            spawn_life = SPAWN_LIFE_RST;
            for (int i = 0; i < POOL_SIZE; i++) begin
                life[i]  = '0;
                pos_x[i] = '0;
                pos_y[i] = '0;
                vel_x[i] = '0;
                vel_y[i] = '0;
                gray[i]  = '0;
                alpha[i] = '0;
            end
            last_slot     = 0;
            errors        = 0;
            spawns        = 0;
            ticks         = 0;
            beats_checked = 0;
        endfunction

        // floor((v + 2^15) / 2^16)
        function longint round16(longint v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function logic signed [POS_W-1:0] sat24(longint v);
            if (v > 64'sd8388607)
                return 24'h7FFFFF;
            if (v < -64'sd8388608)
                return 24'h800000;
            return v[POS_W-1:0];
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [LIFE_W-1:0] data);
            case (idx)
                CFG_FADE_RATE:  fade_rate  = data[FADE_W-1:0];
                CFG_VEL_SCALE:  vel_scale  = data[VSC_W-1:0];
                CFG_SPAWN_LIFE: spawn_life = data;
                default: ;
            endcase
        endfunction

        // Advance the pool by one accepted command and queue the beats it causes
        function void apply_command(logic cmd, t_in_item it);
            int         slot;
            bit         found;
            longint     n;
            longint     jit;
            longint     g;
            longint     dt;
            longint     fade;
            t_slot_beat beat;
            if (cmd == CMD_SPAWN) begin
                spawns++;
                found = 1'b0;
                slot  = 0;
                // first dead slot from the last used one, then wrap
                for (int i = last_slot; i < POOL_SIZE; i++)
                    if (!found && life[i] == '0) begin
                        slot  = i;
                        found = 1'b1;
                    end
                for (int i = 0; i < last_slot; i++)
                    if (!found && life[i] == '0) begin
                        slot  = i;
                        found = 1'b1;
                    end
                last_slot = slot;
                n   = longint'($signed(it.rand_pos)) * 256;
                jit = (n >= 0) ? (n + 5) / 10 : -((-n + 5) / 10);
                g   = 128 + (longint'(it.rand_color) * 256 + 50) / 100;
                if (g > 511)
                    g = 511;
                pos_x[slot] = sat24(longint'($signed(it.obj_pos_x)) + jit
                                    + longint'($signed(it.offset_x)));
                pos_y[slot] = sat24(longint'($signed(it.obj_pos_y)) + jit
                                    + longint'($signed(it.offset_y)));
                vel_x[slot] = sat24(round16(longint'($signed(it.obj_vel_x))
                                            * longint'(vel_scale)));
                vel_y[slot] = sat24(round16(longint'($signed(it.obj_vel_y))
                                            * longint'(vel_scale)));
                gray[slot]  = g[GRAY_W-1:0];
                alpha[slot] = 9'd256;
                life[slot]  = spawn_life;
            end else begin
                ticks++;
                dt   = longint'(it.tick_dt);
                fade = round16(dt * longint'(fade_rate));
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (longint'(life[i]) > dt) begin
                        life[i]  = life[i] - dt[LIFE_W-1:0];
                        pos_x[i] = sat24(longint'(pos_x[i]) - round16(longint'(vel_x[i]) * dt));
                        pos_y[i] = sat24(longint'(pos_y[i]) - round16(longint'(vel_y[i]) * dt));
                        if (longint'(alpha[i]) > fade)
                            alpha[i] = alpha[i] - fade[ALPHA_W-1:0];
                        else
                            alpha[i] = '0;
                    end else begin
                        life[i] = '0;
                    end
                    beat.alive = (life[i] != '0);
                    beat.pos_x = pos_x[i];
                    beat.pos_y = pos_y[i];
                    beat.gray  = gray[i];
                    beat.alpha = alpha[i];
                    beat.last  = (i == POOL_SIZE - 1);
                    expected_slots.insert(expected_slots.size(), beat);
                end
            end
        endfunction

        // Compare one accepted slot beat with the oldest one queued
        function void check_slot_beat(logic [71:0] data, logic alive, logic last);
            t_slot_beat exp_beat;
            t_slot_beat got;
            if (expected_slots.size() == 0) begin
                $error("slot beat with nothing expected: tdata %h", data);
                errors++;
                return;
            end
            exp_beat  = expected_slots.pop_front();
            got.alive = alive;
            got.pos_x = data[23:0];
            got.pos_y = data[47:24];
            got.gray  = data[56:48];
            got.alpha = data[65:57];
            got.last  = last;
            beats_checked++;
            if (got.alive !== exp_beat.alive) begin
                $error("out_alive: expected %0d, actual %0d", exp_beat.alive, got.alive);
                errors++;
            end
            if (got.pos_x !== exp_beat.pos_x) begin
                $error("out_pos_x: expected %0d, actual %0d", exp_beat.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== exp_beat.pos_y) begin
                $error("out_pos_y: expected %0d, actual %0d", exp_beat.pos_y, got.pos_y);
                errors++;
            end
            if (got.gray !== exp_beat.gray) begin
                $error("out_gray: expected %0d, actual %0d", exp_beat.gray, got.gray);
                errors++;
            end
            if (got.alpha !== exp_beat.alpha) begin
                $error("out_alpha: expected %0d, actual %0d", exp_beat.alpha, got.alpha);
                errors++;
            end
            if (got.last !== exp_beat.last) begin
                $error("out_last: expected %0d, actual %0d", exp_beat.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [175:0]         s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LIFE_W-1:0]    i_cfg_data;

    pool_scoreboard sb;
    int             burst_left = 0;
    int             cfg_writes = 0;
    int             idle_cycles = 0;

    particle_pool_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: runs of ready broken by short stalls, now and then a long clean run
    initial begin : receiver
        int run_left;
        int stall_left;
        run_left      = 0;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left > 0) begin
                m_axis_tready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                run_left   = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 12);
                stall_left = $urandom_range(1, 6);
            end
        end
    end

    // Check every accepted slot beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_slot_beat(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end

    // Count cycles in which no channel moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        @(posedge i_clk);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Send one command beat; the sender idles between bursts of random length
    task automatic push_command(input logic cmd, input t_in_item it);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.apply_command(cmd, it);
        burst_left--;
    endtask

    // Drain all expected beats, then let a trailing spawn finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIFE_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.note_config(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item spawn_fields(logic [23:0] px, logic [23:0] py,
                                              logic [23:0] vx, logic [23:0] vy,
                                              logic [23:0] ox, logic [23:0] oy,
                                              int rp, int rc);
        t_in_item it;
        it            = '0;
        it.tick_dt    = DT_W'($urandom);
        it.obj_pos_x  = px;
        it.obj_pos_y  = py;
        it.obj_vel_x  = vx;
        it.obj_vel_y  = vy;
        it.offset_x   = ox;
        it.offset_y   = oy;
        it.rand_pos   = rp[RAND_W-1:0];
        it.rand_color = rc[RAND_W-1:0];
        return it;
    endfunction

    // Position-like value: mostly full range, with extremes and small values mixed in
    function automatic logic [23:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'(int'($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_fields(int dt_max);
        t_in_item it;
        it = spawn_fields(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                          ($urandom_range(0, 9) == 0) ? int'($urandom)
                                                      : int'($urandom_range(0, 99)) - 50,
                          ($urandom_range(0, 9) == 0) ? int'($urandom)
                                                      : int'($urandom_range(0, 99)));
        case ($urandom_range(0, 7))
            0:       it.tick_dt = '0;
            1:       it.tick_dt = dt_max[DT_W-1:0];
            default: it.tick_dt = DT_W'($urandom_range(0, dt_max));
        endcase
        return it;
    endfunction

    function automatic t_in_item tick_fields(int dt);
        t_in_item it;
        it         = random_fields(1);
        it.tick_dt = dt[DT_W-1:0];
        return it;
    endfunction

    // One random phase under a fixed register setting
    task automatic run_phase(input logic [LIFE_W-1:0] fade, input logic [LIFE_W-1:0] vsc,
                             input logic [LIFE_W-1:0] slife, input int n_items,
                             input int spawn_pct, input int dt_max);
        write_reg(CFG_FADE_RATE, fade);
        write_reg(CFG_VEL_SCALE, vsc);
        write_reg(CFG_SPAWN_LIFE, slife);
        for (int k = 0; k < n_items; k++)
            push_command(($urandom_range(0, 99) < spawn_pct) ? CMD_SPAWN : CMD_TICK,
                         random_fields(dt_max));
    endtask

    initial begin : main
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pool, saturating spawns, odd codes, extreme ticks
        push_command(CMD_TICK, tick_fields(0));
        push_command(CMD_SPAWN, spawn_fields(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                                             24'h7FFFFF, 24'h800000, 49, 99));
        push_command(CMD_SPAWN, spawn_fields(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                             24'h800000, 24'h7FFFFF, -50, 0));
        push_command(CMD_SPAWN, spawn_fields(24'd0, 24'd0, 24'd1000, -24'sd1000,
                                             24'd0, 24'd0, 63, 127));
        push_command(CMD_SPAWN, spawn_fields(24'd100, -24'sd100, -24'sd1, 24'd1,
                                             24'd5, -24'sd5, -64, 100));
        push_command(CMD_SPAWN, spawn_fields(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1, 50));
        push_command(CMD_SPAWN, spawn_fields(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, -1, 1));
        push_command(CMD_TICK, tick_fields(1));
        push_command(CMD_TICK, tick_fields(30000));
        push_command(CMD_TICK, tick_fields(0));
        push_command(CMD_TICK, tick_fields(65535));

        // Zero spawn life: slots load but stay dead; fade write carries bits above its width
        write_reg(CFG_SPAWN_LIFE, 17'd0);
        write_reg(CFG_FADE_RATE, 17'h1FFFF);
        write_reg(CFG_VEL_SCALE, 17'd65535);
        write_reg(CFG_UNUSED, 17'h15A5A);
        push_command(CMD_SPAWN, random_fields(65535));
        push_command(CMD_SPAWN, random_fields(65535));
        push_command(CMD_TICK, tick_fields(65535));

        // Longest life, no fade, no inherited velocity
        write_reg(CFG_SPAWN_LIFE, 17'd131071);
        write_reg(CFG_FADE_RATE, 17'd0);
        write_reg(CFG_VEL_SCALE, 17'd0);
        push_command(CMD_SPAWN, random_fields(65535));
        push_command(CMD_SPAWN, random_fields(65535));
        push_command(CMD_TICK, tick_fields(65535));
        push_command(CMD_TICK, tick_fields(1));
        push_command(CMD_TICK, tick_fields(65535));

        // Random phases; the second keeps particles alive long enough to fill the pool
        run_phase(17'(FADE_RATE_RST), 17'(VEL_SCALE_RST), SPAWN_LIFE_RST, 40, 60, 65535);
        run_phase(17'($urandom), 17'($urandom), 17'd131071, 50, 85, 600);
        run_phase(17'($urandom), 17'($urandom), 17'($urandom), 40, 50, 65535);
        run_phase(17'd4095, 17'd65535, 17'd300, 30, 55, 400);
        run_phase(17'd0, 17'd0, 17'($urandom), 40, 50, 65535);

        wait_idle();
        $display("Run covered %0d spawns and %0d ticks, %0d slot beats checked,",
                 sb.spawns, sb.ticks, sb.beats_checked);
        $display("over %0d register writes and %0d mismatches", cfg_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
